// ===== hdl/cau_pkg.sv =====
package cau_pkg;

  localparam int W     = 32;
  localparam int F     = 16;
  localparam int PW    = 2 * W;
  localparam int SW    = PW + 1;
  localparam int MW    = PW - F;
  localparam int SQW   = W + 3;
  localparam int NCELL = W;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_CONJ = 3'd4;
  localparam logic [2:0] OP_MAG  = 3'd5;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  // One part of a result on its way down the chain. Outside a divide, rem holds the magnitude.
  typedef struct packed {
    logic          neg;
    logic          big;
    logic [PW-1:0] rem;
    logic [W-1:0]  bits;
    logic [W-1:0]  quo;
  } lane_t;

  typedef struct packed {
    logic [PW-1:0]  n;
    logic [SQW-1:0] rem;
    logic [W-1:0]   root;
  } sqrt_t;

  typedef struct packed {
    logic [2:0]    kind;
    logic          dz;
    logic [PW-1:0] den;
    lane_t         re;
    lane_t         im;
    sqrt_t         sq;
  } cell_t;

endpackage

// ===== hdl/cau_if.sv =====
interface cau_in_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    kind;
  logic signed [cau_pkg::W-1:0]  a_real;
  logic signed [cau_pkg::W-1:0]  a_imag;
  logic signed [cau_pkg::W-1:0]  b_real;
  logic signed [cau_pkg::W-1:0]  b_imag;

  modport source (output valid, kind, a_real, a_imag, b_real, b_imag, input ready);
  modport sink (input valid, kind, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [cau_pkg::W-1:0]  res_real;
  logic signed [cau_pkg::W-1:0]  res_imag;
  logic [1:0]                    status;

  modport source (output valid, res_real, res_imag, status, input ready);
  modport sink (input valid, res_real, res_imag, status, output ready);
endinterface

// ===== hdl/cau_front.sv =====
module cau_front (
  input  logic            clk,
  input  logic            rst_n,
  cau_in_if.sink          up,
  output logic            dn_valid,
  input  logic            dn_ready,
  output cau_pkg::cell_t  dn_data
);

  localparam int W  = cau_pkg::W;
  localparam int F  = cau_pkg::F;
  localparam int PW = cau_pkg::PW;
  localparam int SW = cau_pkg::SW;

  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;

  logic [2:0]           kind1_r;
  logic signed [W-1:0]  ar1_r, ai1_r, br1_r, bi1_r;
  logic signed [PW-1:0] prr1_r, pii1_r, pri1_r, pir1_r;
  logic signed [PW-1:0] sq01_r, sq11_r;

  logic signed [PW-1:0] prr, pii, pri, pir, sq0, sq1;
  logic signed [W-1:0]  x0, x1;

  logic [2:0]           kind2_r;
  logic signed [SW-1:0] sre2_r, sim2_r;
  logic [PW-1:0]        nsum2_r;
  logic signed [SW-1:0] sre, sim;
  logic [PW-1:0]        nsum;

  cau_pkg::cell_t       cell_r, cell_nxt;
  logic [SW-1:0]        abs_re, abs_im;
  logic [PW-1:0]        mag_re, mag_im;
  logic                 is_div;

  assign adv3     = !v3_r || dn_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign up.ready = adv1;
  assign dn_valid = v3_r;
  assign dn_data  = cell_r;

  assign x0  = (up.kind == cau_pkg::OP_MAG) ? up.a_real : up.b_real;
  assign x1  = (up.kind == cau_pkg::OP_MAG) ? up.a_imag : up.b_imag;
  assign prr = PW'(up.a_real) * PW'(up.b_real);
  assign pii = PW'(up.a_imag) * PW'(up.b_imag);
  assign pri = PW'(up.a_real) * PW'(up.b_imag);
  assign pir = PW'(up.a_imag) * PW'(up.b_real);
  assign sq0 = PW'(x0) * PW'(x0);
  assign sq1 = PW'(x1) * PW'(x1);

  always_comb begin
    sre = '0;
    sim = '0;
    case (kind1_r)
      cau_pkg::OP_ADD: begin
        sre = SW'(ar1_r) + SW'(br1_r);
        sim = SW'(ai1_r) + SW'(bi1_r);
      end
      cau_pkg::OP_SUB: begin
        sre = SW'(ar1_r) - SW'(br1_r);
        sim = SW'(ai1_r) - SW'(bi1_r);
      end
      cau_pkg::OP_MUL: begin
        sre = SW'(prr1_r) - SW'(pii1_r);
        sim = SW'(pri1_r) + SW'(pir1_r);
      end
      cau_pkg::OP_DIV: begin
        sre = SW'(prr1_r) + SW'(pii1_r);
        sim = SW'(pir1_r) - SW'(pri1_r);
      end
      cau_pkg::OP_CONJ: begin
        sre = SW'(ar1_r);
        sim = -SW'(ai1_r);
      end
      default: begin
        sre = '0;
        sim = '0;
      end
    endcase
    nsum = PW'(sq01_r) + PW'(sq11_r);
  end

  always_comb begin
    abs_re = sre2_r[SW-1] ? SW'(-sre2_r) : SW'(sre2_r);
    abs_im = sim2_r[SW-1] ? SW'(-sim2_r) : SW'(sim2_r);
    mag_re = abs_re[PW-1:0];
    mag_im = abs_im[PW-1:0];
    is_div = (kind2_r == cau_pkg::OP_DIV);

    cell_nxt.kind = kind2_r;
    cell_nxt.dz   = (nsum2_r == '0);
    cell_nxt.den  = nsum2_r;

    cell_nxt.re.neg = sre2_r[SW-1];
    cell_nxt.re.quo = '0;
    cell_nxt.im.neg = sim2_r[SW-1];
    cell_nxt.im.quo = '0;
    if (is_div) begin
      cell_nxt.re.big  = ({{(W-F){1'b0}}, mag_re} >= {nsum2_r, {(W-F){1'b0}}});
      cell_nxt.re.rem  = mag_re >> (W - F);
      cell_nxt.re.bits = {mag_re[W-F-1:0], {F{1'b0}}};
      cell_nxt.im.big  = ({{(W-F){1'b0}}, mag_im} >= {nsum2_r, {(W-F){1'b0}}});
      cell_nxt.im.rem  = mag_im >> (W - F);
      cell_nxt.im.bits = {mag_im[W-F-1:0], {F{1'b0}}};
    end else begin
      cell_nxt.re.big  = 1'b0;
      cell_nxt.re.rem  = mag_re;
      cell_nxt.re.bits = '0;
      cell_nxt.im.big  = 1'b0;
      cell_nxt.im.rem  = mag_im;
      cell_nxt.im.bits = '0;
    end

    cell_nxt.sq.n    = nsum2_r;
    cell_nxt.sq.rem  = '0;
    cell_nxt.sq.root = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= up.valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      kind1_r <= up.kind;
      ar1_r   <= up.a_real;
      ai1_r   <= up.a_imag;
      br1_r   <= up.b_real;
      bi1_r   <= up.b_imag;
      prr1_r  <= prr;
      pii1_r  <= pii;
      pri1_r  <= pri;
      pir1_r  <= pir;
      sq01_r  <= sq0;
      sq11_r  <= sq1;
    end
    if (adv2) begin
      kind2_r <= kind1_r;
      sre2_r  <= sre;
      sim2_r  <= sim;
      nsum2_r <= nsum;
    end
    if (adv3) begin
      cell_r <= cell_nxt;
    end
  end

endmodule

// ===== hdl/cau_cell.sv =====
module cau_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  cau_pkg::cell_t  up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output cau_pkg::cell_t  dn_data
);

  localparam int W   = cau_pkg::W;
  localparam int PW  = cau_pkg::PW;
  localparam int SQW = cau_pkg::SQW;

  logic           valid_r;
  logic           adv;
  cau_pkg::cell_t data_r, data_nxt;

  logic [PW:0]    r_re, r_im, d_re, d_im, den_x;
  logic           ge_re, ge_im;
  logic [SQW-1:0] r_sq, t_sq, d_sq;
  logic           ge_sq;

  assign adv      = !valid_r || dn_ready;
  assign up_ready = adv;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    den_x = {1'b0, up_data.den};
    r_re  = {up_data.re.rem, up_data.re.bits[W-1]};
    r_im  = {up_data.im.rem, up_data.im.bits[W-1]};
    ge_re = (r_re >= den_x);
    ge_im = (r_im >= den_x);
    d_re  = r_re - den_x;
    d_im  = r_im - den_x;

    r_sq  = {up_data.sq.rem[SQW-3:0], up_data.sq.n[PW-1:PW-2]};
    t_sq  = {1'b0, up_data.sq.root, 2'b01};
    ge_sq = (r_sq >= t_sq);
    d_sq  = r_sq - t_sq;

    data_nxt = up_data;
    if (up_data.kind == cau_pkg::OP_DIV) begin
      data_nxt.re.rem  = ge_re ? d_re[PW-1:0] : r_re[PW-1:0];
      data_nxt.re.bits = {up_data.re.bits[W-2:0], 1'b0};
      data_nxt.re.quo  = {up_data.re.quo[W-2:0], ge_re};
      data_nxt.im.rem  = ge_im ? d_im[PW-1:0] : r_im[PW-1:0];
      data_nxt.im.bits = {up_data.im.bits[W-2:0], 1'b0};
      data_nxt.im.quo  = {up_data.im.quo[W-2:0], ge_im};
    end
    if (up_data.kind == cau_pkg::OP_MAG) begin
      data_nxt.sq.rem  = ge_sq ? d_sq : r_sq;
      data_nxt.sq.root = {up_data.sq.root[W-2:0], ge_sq};
      data_nxt.sq.n    = {up_data.sq.n[PW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== hdl/cau_back.sv =====
module cau_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  cau_pkg::cell_t  up_data,
  cau_out_if.source       dn
);

  localparam int W   = cau_pkg::W;
  localparam int F   = cau_pkg::F;
  localparam int PW  = cau_pkg::PW;
  localparam int MW  = cau_pkg::MW;
  localparam int SQW = cau_pkg::SQW;

  localparam logic [MW-1:0] LIM_POS = (MW'(1) << (W - 1)) - MW'(1);
  localparam logic [MW-1:0] LIM_NEG = MW'(1) << (W - 1);

  logic v1_r, v2_r;
  logic adv1, adv2;

  logic          nre_r, nim_r, bre_r, bim_r, dz_r;
  logic [MW-1:0] mre_r, mim_r;
  logic          nre, nim, bre, bim, dz;
  logic [MW-1:0] mre, mim;
  logic [PW:0]   t_re, t_im;
  logic          rnd_re, rnd_im, rnd_sq;

  logic [MW-1:0] lim_re, lim_im;
  logic          sat_re, sat_im;
  logic [W-1:0]  v_re, v_im;

  logic [W-1:0]  res_re_r, res_im_r;
  logic [1:0]    status_r;

  assign adv2     = !v2_r || dn.ready;
  assign adv1     = !v1_r || adv2;
  assign up_ready = adv1;

  assign dn.valid    = v2_r;
  assign dn.res_real = res_re_r;
  assign dn.res_imag = res_im_r;
  assign dn.status   = status_r;

  always_comb begin
    t_re   = {1'b0, up_data.re.rem} + (PW+1)'(1 << (F - 1));
    t_im   = {1'b0, up_data.im.rem} + (PW+1)'(1 << (F - 1));
    rnd_re = ({up_data.re.rem, 1'b0} >= {1'b0, up_data.den});
    rnd_im = ({up_data.im.rem, 1'b0} >= {1'b0, up_data.den});
    rnd_sq = (up_data.sq.rem > SQW'(up_data.sq.root));

    nre = up_data.re.neg;
    nim = up_data.im.neg;
    bre = 1'b0;
    bim = 1'b0;
    dz  = 1'b0;
    mre = '0;
    mim = '0;
    case (up_data.kind) inside
      cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_CONJ: begin
        mre = up_data.re.rem[MW-1:0];
        mim = up_data.im.rem[MW-1:0];
      end
      cau_pkg::OP_MUL: begin
        mre = t_re[PW-1:F];
        mim = t_im[PW-1:F];
      end
      cau_pkg::OP_DIV: begin
        if (up_data.dz) begin
          dz  = 1'b1;
          nre = 1'b0;
          nim = 1'b0;
        end else begin
          mre = MW'(up_data.re.quo) + MW'(rnd_re);
          mim = MW'(up_data.im.quo) + MW'(rnd_im);
          bre = up_data.re.big;
          bim = up_data.im.big;
        end
      end
      cau_pkg::OP_MAG: begin
        nre = 1'b0;
        nim = 1'b0;
        mre = MW'(up_data.sq.root) + MW'(rnd_sq);
      end
      default: begin
        nre = 1'b0;
        nim = 1'b0;
      end
    endcase
  end

  always_comb begin
    lim_re = nre_r ? LIM_NEG : LIM_POS;
    lim_im = nim_r ? LIM_NEG : LIM_POS;
    sat_re = bre_r || (mre_r > lim_re);
    sat_im = bim_r || (mim_r > lim_im);
    v_re   = sat_re ? lim_re[W-1:0] : mre_r[W-1:0];
    v_im   = sat_im ? lim_im[W-1:0] : mim_r[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= up_valid;
      if (adv2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      nre_r <= nre;
      nim_r <= nim;
      bre_r <= bre;
      bim_r <= bim;
      dz_r  <= dz;
      mre_r <= mre;
      mim_r <= mim;
    end
    if (adv2) begin
      res_re_r <= nre_r ? W'(-v_re) : v_re;
      res_im_r <= nim_r ? W'(-v_im) : v_im;
      if (dz_r) begin
        status_r <= cau_pkg::ST_DZ;
      end else if (sat_re || sat_im) begin
        status_r <= cau_pkg::ST_SAT;
      end else begin
        status_r <= cau_pkg::ST_OK;
      end
    end
  end

endmodule

// ===== hdl/complex_arithmetic_unit.sv =====
// Channel   Direction  Contents
// in_ch     sink       kind, a_real, a_imag, b_real, b_imag
// out_ch    source     res_real, res_imag, status
//
// One item is accepted per cycle while the first stage can move; each passes through
// three front stages (products, sums, magnitudes), 32 chained cells that each produce
// one quotient bit or one square root bit, and two back stages (rounding, saturation).
// Reset clears every stage's valid bit; data registers are not reset.
// Every stage holds when the stage below it is full and not moving, so bubbles close up.
module complex_arithmetic_unit (
  input  logic        clk,
  input  logic        rst_n,
  cau_in_if.sink      in_ch,
  cau_out_if.source   out_ch
);

  localparam int NCELL = cau_pkg::NCELL;

  logic           c_valid [NCELL+1];
  logic           c_ready [NCELL+1];
  cau_pkg::cell_t c_data  [NCELL+1];

  cau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up       (in_ch),
    .dn_valid (c_valid[0]),
    .dn_ready (c_ready[0]),
    .dn_data  (c_data[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cau_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (c_valid[i]),
      .up_ready (c_ready[i]),
      .up_data  (c_data[i]),
      .dn_valid (c_valid[i+1]),
      .dn_ready (c_ready[i+1]),
      .dn_data  (c_data[i+1])
    );
  end

  cau_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (c_valid[NCELL]),
    .up_ready (c_ready[NCELL]),
    .up_data  (c_data[NCELL]),
    .dn       (out_ch)
  );

endmodule
